// ===== src/bcpe_pkg.sv =====
package bcpe_pkg;

  // Sizing of the pad runs and of the message length counter.
  localparam int MAX_PAD     = 64;
  localparam int LENGTH_BITS = 16;
  localparam int CNT_W       = $clog2(MAX_PAD + 1);
  localparam int IDX_W       = (MAX_PAD > 1) ? $clog2(MAX_PAD) : 1;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_SCHEME_IDX = 1'b0;

  // Padding schemes.
  localparam logic [1:0] SCHEME_PKCS7    = 2'd0;
  localparam logic [1:0] SCHEME_ONE_ZERO = 2'd1;
  localparam logic [1:0] SCHEME_X923     = 2'd2;
  localparam logic [1:0] SCHEME_RESERVED = 2'd3;

  // Input commands and result kinds.
  localparam logic CMD_PAD      = 1'b0;
  localparam logic CMD_UNPAD    = 1'b1;
  localparam logic KIND_PAD     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Pad byte constants.
  localparam logic [7:0] BYTE_MARK = 8'h80;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] RUN_MAX   = 8'hFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pad_start;
    logic pad_emit;
    logic unpad_step;
    logic verdict_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pad_empty;
    logic pad_last;
  } dp_status_t;

endpackage

// ===== src/bcpe_regs.sv =====
module bcpe_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bcpe_pkg::PADDR_W-1:0]    paddr,
  input  logic [bcpe_pkg::PDATA_W-1:0]    pwdata,
  output logic [bcpe_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output logic [1:0]                      scheme_mode
);
  import bcpe_pkg::*;

  logic reg_hit;

  // Register index is the word address.
  assign reg_hit = (paddr[PADDR_W-1] == REG_SCHEME_IDX);
  assign pready  = 1'b1;

  // Scheme register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      scheme_mode <= SCHEME_PKCS7;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      scheme_mode <= pwdata[1:0];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(PDATA_W-2){1'b0}}, scheme_mode};
    end
  end

endmodule

// ===== src/bcpe_ctrl.sv =====
module bcpe_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic                   end_of_message,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  bcpe_pkg::dp_status_t   status,
  output bcpe_pkg::dp_cmd_t      ctl
);
  import bcpe_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_PAD
  } state_t;

  state_t state;
  logic   slot_free;
  logic   accept;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  // Datapath commands.
  always_comb begin
    ctl.pad_start    = accept && (cmd == CMD_PAD) && !status.pad_empty;
    ctl.unpad_step   = accept && (cmd == CMD_UNPAD);
    ctl.verdict_load = accept && (cmd == CMD_UNPAD) && end_of_message;
    ctl.pad_emit     = (state == ST_PAD) && slot_free;
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ctl.pad_start) begin
            state <= ST_PAD;
          end
        end
        ST_PAD: begin
          if (ctl.pad_emit && status.pad_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (ctl.pad_emit || ctl.verdict_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/bcpe_dp.sv =====
module bcpe_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [1:0]                          scheme_mode,
  input  logic [7:0]                          data_byte,
  input  logic [6:0]                          pad_count,
  input  bcpe_pkg::dp_cmd_t                   ctl,
  output bcpe_pkg::dp_status_t                status,
  output logic                                result_kind,
  output logic [7:0]                          pad_byte,
  output logic                                run_last,
  output logic                                verdict,
  output logic [15:0]                         payload_length
);
  import bcpe_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Pad run state.
  logic [CNT_W-1:0]       run_count;
  logic [IDX_W-1:0]       run_idx;
  logic [CNT_W-1:0]       count_sat;
  logic [7:0]             pad_value;

  // Unpad state.
  logic [LENGTH_BITS-1:0] message_count;
  logic [7:0]             equal_run;
  logic [7:0]             previous_value;
  logic [7:0]             zero_run;
  logic [LENGTH_BITS-1:0] nonzero_index;
  logic [7:0]             nonzero_value;
  logic                   nonzero_seen;
  logic                   length_overflow;

  logic [LENGTH_BITS-1:0] message_count_next;
  logic [7:0]             equal_run_next;
  logic [7:0]             zero_run_next;
  logic [LENGTH_BITS-1:0] nonzero_index_next;
  logic [7:0]             nonzero_value_next;
  logic                   nonzero_seen_next;
  logic                   length_overflow_next;

  logic [LENGTH_BITS-1:0] byte_ext;
  logic                   bad;
  logic [LENGTH_BITS-1:0] payload;

  // Saturate the requested count to the longest run.
  always_comb begin
    if (pad_count > 7'(MAX_PAD)) begin
      count_sat = CNT_W'(MAX_PAD);
    end else begin
      count_sat = CNT_W'(pad_count);
    end
  end

  assign status.pad_empty = (pad_count == 7'd0) || (scheme_mode == SCHEME_RESERVED);
  assign status.pad_last  = (CNT_W'(run_idx) + CNT_W'(1)) == run_count;

  // Byte of the current pad position.
  always_comb begin
    case (scheme_mode)
      SCHEME_PKCS7:    pad_value = 8'(run_count);
      SCHEME_ONE_ZERO: pad_value = (run_idx == '0) ? BYTE_MARK : BYTE_ZERO;
      SCHEME_X923:     pad_value = status.pad_last ? 8'(run_count) : BYTE_ZERO;
      default:         pad_value = BYTE_ZERO;
    endcase
  end

  // Pad run counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
      run_idx   <= '0;
    end else if (ctl.pad_start) begin
      run_count <= count_sat;
      run_idx   <= '0;
    end else if (ctl.pad_emit) begin
      run_idx   <= run_idx + IDX_W'(1);
    end
  end

  // Unpad trackers after the incoming byte.
  always_comb begin
    byte_ext = LENGTH_BITS'(data_byte);

    length_overflow_next = length_overflow;
    message_count_next   = message_count;
    if (message_count >= LEN_MAX) begin
      length_overflow_next = 1'b1;
    end else begin
      message_count_next = message_count + LENGTH_BITS'(1);
    end

    if ((message_count == '0) || (data_byte != previous_value)) begin
      equal_run_next = 8'd1;
    end else if (equal_run < RUN_MAX) begin
      equal_run_next = equal_run + 8'd1;
    end else begin
      equal_run_next = equal_run;
    end

    zero_run_next      = zero_run;
    nonzero_index_next = nonzero_index;
    nonzero_value_next = nonzero_value;
    nonzero_seen_next  = nonzero_seen;
    if (data_byte == BYTE_ZERO) begin
      if (zero_run < RUN_MAX) begin
        zero_run_next = zero_run + 8'd1;
      end
    end else begin
      zero_run_next      = 8'd0;
      nonzero_index_next = message_count;
      nonzero_value_next = data_byte;
      nonzero_seen_next  = 1'b1;
    end
  end

  // Verdict on the final byte.
  always_comb begin
    bad     = 1'b0;
    payload = '0;
    case (scheme_mode) inside
      SCHEME_PKCS7, SCHEME_X923: begin
        if ((data_byte == BYTE_ZERO) || (byte_ext > message_count_next)) begin
          bad = 1'b1;
        end else if ((scheme_mode == SCHEME_PKCS7) && (equal_run_next < data_byte)) begin
          bad = 1'b1;
        end else if ((scheme_mode == SCHEME_X923) && (zero_run < (data_byte - 8'd1))) begin
          bad = 1'b1;
        end else begin
          payload = message_count_next - byte_ext;
        end
      end
      SCHEME_ONE_ZERO: begin
        if (!nonzero_seen_next || (nonzero_value_next != BYTE_MARK)) begin
          bad = 1'b1;
        end else begin
          payload = nonzero_index_next;
        end
      end
      default: bad = 1'b1;
    endcase
    if (length_overflow_next) begin
      bad = 1'b1;
    end
    if (bad) begin
      payload = '0;
    end
  end

  // Unpad state registers; cleared after each verdict.
  always_ff @(posedge clk) begin
    if (rst || ctl.verdict_load) begin
      message_count   <= '0;
      equal_run       <= '0;
      previous_value  <= '0;
      zero_run        <= '0;
      nonzero_index   <= '0;
      nonzero_value   <= '0;
      nonzero_seen    <= 1'b0;
      length_overflow <= 1'b0;
    end else if (ctl.unpad_step) begin
      message_count   <= message_count_next;
      equal_run       <= equal_run_next;
      previous_value  <= data_byte;
      zero_run        <= zero_run_next;
      nonzero_index   <= nonzero_index_next;
      nonzero_value   <= nonzero_value_next;
      nonzero_seen    <= nonzero_seen_next;
      length_overflow <= length_overflow_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.verdict_load) begin
      result_kind    <= KIND_VERDICT;
      pad_byte       <= BYTE_ZERO;
      run_last       <= 1'b1;
      verdict        <= bad;
      payload_length <= 16'(payload);
    end else if (ctl.pad_emit) begin
      result_kind    <= KIND_PAD;
      pad_byte       <= pad_value;
      run_last       <= status.pad_last;
      verdict        <= 1'b0;
      payload_length <= 16'd0;
    end
  end

endmodule

// ===== src/block_cipher_padding_engine.sv =====
// Pad request of n bytes (n saturated to 64, none for n = 0 or reserved scheme):
// accepted, then one pad byte per cycle unless out_ready stalls (pad run counter).
// Unpad bytes: one per cycle unless stalled; verdict in the cycle after the last.
// Reset (rst, synchronous, active high) selects PKCS#7, clears the message trackers
// and empties the output register.
module block_cipher_padding_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bcpe_pkg::PADDR_W-1:0]    paddr,
  input  logic [bcpe_pkg::PDATA_W-1:0]    pwdata,
  output logic [bcpe_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [7:0]                      data_byte,
  input  logic                            end_of_message,
  input  logic [6:0]                      pad_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            result_kind,
  output logic [7:0]                      pad_byte,
  output logic                            run_last,
  output logic                            verdict,
  output logic [15:0]                     payload_length
);
  import bcpe_pkg::*;

  logic [1:0] scheme_mode;
  dp_cmd_t    ctl;
  dp_status_t status;

  // Configuration register.
  bcpe_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .scheme_mode (scheme_mode)
  );

  // Handshake and sequencing.
  bcpe_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .ctl            (ctl)
  );

  // Pad generation, unpad tracking and result register.
  bcpe_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .scheme_mode    (scheme_mode),
    .data_byte      (data_byte),
    .pad_count      (pad_count),
    .ctl            (ctl),
    .status         (status),
    .result_kind    (result_kind),
    .pad_byte       (pad_byte),
    .run_last       (run_last),
    .verdict        (verdict),
    .payload_length (payload_length)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bcpe_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = MAX_PAD + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 18;

  typedef struct {
    logic       cmd;
    logic [7:0] data_byte;
    logic       eom;
    logic [6:0] pad_count;
  } pad_item_t;

  typedef struct {
    logic        kind;
    logic [7:0]  pad_byte;
    logic        run_last;
    logic        verdict;
    logic [15:0] payload_length;
  } pad_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CMD_PAD;
  logic [7:0]         data_byte = '0;
  logic               end_of_message = 1'b0;
  logic [6:0]         pad_count = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               result_kind;
  logic [7:0]         pad_byte;
  logic               run_last;
  logic               verdict;
  logic [15:0]        payload_length;

  // Shadow of the scheme register and of the message trackers.
  logic [1:0]  scheme = SCHEME_PKCS7;
  logic [15:0] msg_count = '0;
  logic [7:0]  equal_run = '0;
  logic [7:0]  last_byte = '0;
  logic [7:0]  zero_run = '0;
  logic [15:0] nz_index = '0;
  logic [7:0]  nz_value = '0;
  logic        nz_seen = 1'b0;
  logic        len_overflow = 1'b0;

  pad_item_t   stim_q[$];
  pad_result_t expected_q[$];

  int errors = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_gap = 0;
  int recv_calm = 0;

  block_cipher_padding_engine DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .pad_count      (pad_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .pad_byte       (pad_byte),
    .run_last       (run_last),
    .verdict        (verdict),
    .payload_length (payload_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, a few long, with calm stretches of no gaps.
  function automatic int pick_gap(inout int calm);
    int r;
    if (!gaps_on) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_result(logic kind, logic [7:0] b, logic last, logic bad,
                                      logic [15:0] len);
    pad_result_t r;
    r.kind = kind;
    r.pad_byte = b;
    r.run_last = last;
    r.verdict = bad;
    r.payload_length = len;
    expected_q.push_back(r);
  endfunction

  function automatic void clear_trackers();
    msg_count = '0;
    equal_run = '0;
    last_byte = '0;
    zero_run = '0;
    nz_index = '0;
    nz_value = '0;
    nz_seen = 1'b0;
    len_overflow = 1'b0;
  endfunction

  // Expected pad bytes for one pad request under the current scheme.
  function automatic void predict_pad(logic [6:0] cnt);
    int n;
    logic [7:0] b;
    if (cnt == 0 || scheme == SCHEME_RESERVED) return;
    n = (cnt > MAX_PAD) ? MAX_PAD : int'(cnt);
    for (int i = 0; i < n; i++) begin
      if (scheme == SCHEME_PKCS7) b = 8'(n);
      else if (scheme == SCHEME_ONE_ZERO) b = (i == 0) ? BYTE_MARK : BYTE_ZERO;
      else b = (i == n - 1) ? 8'(n) : BYTE_ZERO;
      push_result(KIND_PAD, b, i == n - 1, 1'b0, 16'd0);
    end
  endfunction

  // Tracker update for one message byte, and the verdict on the final one.
  function automatic void predict_unpad(logic [7:0] b, logic eom);
    int zeros_before;
    int pos;
    int n;
    int bv;
    int payload;
    bit bad;
    zeros_before = zero_run;
    pos = msg_count;
    bv = b;
    bad = 1'b0;
    payload = 0;
    if (msg_count == 16'hFFFF) len_overflow = 1'b1;
    else msg_count = msg_count + 16'd1;
    if (pos == 0 || b != last_byte) equal_run = 8'd1;
    else if (equal_run != RUN_MAX) equal_run = equal_run + 8'd1;
    last_byte = b;
    if (b == BYTE_ZERO) begin
      if (zero_run != RUN_MAX) zero_run = zero_run + 8'd1;
    end else begin
      zero_run = '0;
      nz_index = 16'(pos);
      nz_value = b;
      nz_seen = 1'b1;
    end
    if (!eom) return;
    n = msg_count;
    if (scheme == SCHEME_PKCS7 || scheme == SCHEME_X923) begin
      if (bv == 0 || bv > n) bad = 1'b1;
      else if (scheme == SCHEME_PKCS7 && int'(equal_run) < bv) bad = 1'b1;
      else if (scheme == SCHEME_X923 && zeros_before < bv - 1) bad = 1'b1;
      else payload = n - bv;
    end else if (scheme == SCHEME_ONE_ZERO) begin
      if (!nz_seen || nz_value != BYTE_MARK) bad = 1'b1;
      else payload = nz_index;
    end else begin
      bad = 1'b1;
    end
    if (len_overflow || payload > 65535) bad = 1'b1;
    if (bad) payload = 0;
    push_result(KIND_VERDICT, BYTE_ZERO, 1'b1, bad, 16'(payload));
    clear_trackers();
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Driver: offers queued transactions, predicting each one as it is accepted.
  always @(posedge clk) begin : driver
    logic offer;
    pad_item_t item;
    offer = in_valid;
    if (rst) begin
      offer = 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (cmd == CMD_PAD) predict_pad(pad_count);
        else predict_unpad(data_byte, end_of_message);
        offer = 1'b0;
        send_gap = pick_gap(send_calm);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (stim_q.size() > 0) begin
          item = stim_q.pop_front();
          cmd <= item.cmd;
          data_byte <= item.data_byte;
          end_of_message <= item.eom;
          pad_count <= item.pad_count;
          offer = 1'b1;
        end
      end
    end
    in_valid <= offer;
  end

  // Monitor: checks each accepted result and throttles out_ready.
  always @(posedge clk) begin : monitor
    logic take;
    pad_result_t want;
    take = 1'b1;
    if (rst) begin
      take = 1'b0;
      hold_left = 0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no expected transaction: kind %0d byte 0x%0h",
                 result_kind, pad_byte);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("pad_byte", want.pad_byte, pad_byte);
          check_field("run_last", want.run_last, run_last);
          check_field("verdict", want.verdict, verdict);
          check_field("payload_length", want.payload_length, payload_length);
        end
        recv_gap = pick_gap(recv_calm);
      end else if (gaps_on && recv_gap == 0 && $urandom_range(0, 24) == 0) begin
        recv_gap = $urandom_range(1, 6);
      end
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        take = 1'b0;
      end
    end
    out_ready <= take;
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_pad(logic [6:0] cnt);
    pad_item_t it;
    it.cmd = CMD_PAD;
    it.data_byte = 8'($urandom());
    it.eom = 1'($urandom());
    it.pad_count = cnt;
    stim_q.push_back(it);
  endfunction

  function automatic void push_byte(logic [7:0] b, logic eom);
    pad_item_t it;
    it.cmd = CMD_UNPAD;
    it.data_byte = b;
    it.eom = eom;
    it.pad_count = 7'($urandom());
    stim_q.push_back(it);
  endfunction

  // One message: random body plus padding of the given scheme, possibly corrupted.
  function automatic void queue_message(logic [1:0] mode, bit good);
    logic [7:0] msg[$];
    int body;
    int k;
    int idx;
    body = $urandom_range(0, 12);
    for (int i = 0; i < body; i++) msg.push_back(8'($urandom()));
    k = $urandom_range(1, 16);
    case (mode)
      SCHEME_PKCS7: begin
        repeat (k) msg.push_back(8'(k));
      end
      SCHEME_ONE_ZERO: begin
        msg.push_back(BYTE_MARK);
        repeat (k - 1) msg.push_back(BYTE_ZERO);
      end
      default: begin
        repeat (k - 1) msg.push_back(BYTE_ZERO);
        msg.push_back(8'(k));
      end
    endcase
    if (!good) begin
      case ($urandom_range(0, 2))
        0: begin
          idx = $urandom_range(0, msg.size() - 1);
          msg[idx] = msg[idx] ^ 8'(1 << $urandom_range(0, 7));
        end
        1: begin
          msg[msg.size() - 1] = 8'($urandom());
        end
        default: begin
          msg.delete();
          repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom()));
        end
      endcase
    end
    for (int i = 0; i < msg.size(); i++) begin
      // Now and then a pad request lands in the middle of a message.
      if ($urandom_range(0, 19) == 0) push_pad(7'($urandom_range(0, 10)));
      push_byte(msg[i], i == msg.size() - 1);
    end
  endfunction

  function automatic void queue_random(int count);
    int start;
    logic [1:0] shape;
    start = stim_q.size();
    while (stim_q.size() - start < count) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 9) == 0) push_pad(7'($urandom_range(17, 127)));
        else push_pad(7'($urandom_range(0, 16)));
      end else begin
        shape = (scheme == SCHEME_RESERVED) ? 2'($urandom_range(0, 2)) : scheme;
        queue_message(shape, $urandom_range(0, 3) != 0);
      end
    end
  endfunction

  // Wait until every transaction is accepted and every result has arrived.
  task automatic drain();
    @(negedge clk);
    while (stim_q.size() > 0 || in_valid || expected_q.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_scheme(input logic [1:0] mode);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * REG_SCHEME_IDX);
    pwdata <= ($urandom() & 32'hFFFF_FFFC) | PDATA_W'(mode);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    scheme = mode;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [1:0] modes[7];
    modes = '{SCHEME_PKCS7, SCHEME_ONE_ZERO, SCHEME_X923, SCHEME_RESERVED,
              SCHEME_X923, SCHEME_PKCS7, SCHEME_ONE_ZERO};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // PKCS#7 from reset: empty, short, full and saturated runs, then verdict cases.
    push_pad(7'd0);
    push_pad(7'd1);
    push_pad(7'd64);
    push_pad(7'd127);
    push_byte(8'h41, 1'b0);
    push_byte(8'h02, 1'b0);
    push_pad(7'd2);
    push_byte(8'h02, 1'b1);
    push_byte(8'h01, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    drain();

    // One-and-zeroes: a good message and one with no nonzero byte.
    write_scheme(SCHEME_ONE_ZERO);
    push_pad(7'd3);
    push_byte(8'h55, 1'b0);
    push_byte(BYTE_MARK, 1'b0);
    push_byte(BYTE_ZERO, 1'b1);
    push_byte(BYTE_ZERO, 1'b1);
    drain();

    // X.923: two failing messages, both with nonzero filler before the length byte.
    write_scheme(SCHEME_X923);
    push_pad(7'd4);
    push_byte(8'h11, 1'b0);
    push_byte(BYTE_ZERO, 1'b0);
    push_byte(8'h03, 1'b1);
    push_byte(8'h07, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h03, 1'b1);
    drain();

    // Reserved scheme: pads give nothing, verdicts are invalid.
    write_scheme(SCHEME_RESERVED);
    push_pad(7'd2);
    push_byte(8'h01, 1'b1);
    drain();

    // Random phases over all schemes.
    for (int p = 0; p < 7; p++) begin
      write_scheme(modes[p]);
      if (p == 1) begin
        // Receiver holds off while full pad runs keep coming.
        hold_ask++;
        repeat (4) push_pad(7'd64);
      end
      queue_random(PHASE_ITEMS);
      drain();
    end

    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bcpe_pkg.sv
src/bcpe_regs.sv
src/bcpe_ctrl.sv
src/bcpe_dp.sv
src/block_cipher_padding_engine.sv
tb/sv/tb_top.sv
